@@ rtl/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Beat layouts, operation and status codes, the per-cell entry and the
// control word broadcast along the chain of cells.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 15;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [14:0]        out_priority;
    logic [4:0]         entry_count;
    logic               is_empty;
  } out_beat_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             insert_en;
    logic             pop_en;
    logic             remove_en;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } cell_ctl_t;

endpackage

@@ rtl/spq_cell.sv @@
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares it with the broadcast request and either keeps
// it, takes the new entry, or takes the entry of its left or right neighbor.
// ---------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic             occupied,
  input  entry_t           left_entry,
  input  entry_t           right_entry,
  input  logic             left_le,
  input  logic             seen_in,
  output entry_t           entry,
  output logic             le,
  output logic             seen_out,
  output logic [PRI_W-1:0] hit_priority
);

  entry_t entry_r;
  entry_t entry_nxt;
  entry_t new_entry;
  logic   match;

  assign new_entry    = '{value: ctl.value, prio: ctl.prio};
  assign match        = occupied && (entry_r.value == ctl.value);
  assign le           = occupied && (entry_r.prio <= ctl.prio);
  assign seen_out     = seen_in || match;
  // only the first match from the front reports its priority
  assign hit_priority = (match && !seen_in) ? entry_r.prio : '0;
  assign entry        = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.insert_en) begin
      if (!left_le) begin
        entry_nxt = left_entry;
      end else if (!le) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.pop_en || (ctl.remove_en && seen_out)) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ---------------------------------------------------------------------------
// sorted_priority_queue: sorted list priority queue on a chain of cells
// result: an accepted request loads the request register and busy_r, and the
// result strobe is registered from busy_r; busy is high for the one cycle in
// which the chain updates, and no new request is accepted while busy is high
// reset: synchronous active-low rst_n clears the count, busy and the strobe;
// cell contents are not reset and are read only below the count
// ---------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  // request register, loaded on the accepted beat
  logic      busy_r;
  logic      busy_nxt;
  in_beat_t  cmd_r;
  logic      accept;

  // stored entry count
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;

  // result strobe and beat
  logic      out_valid_r;
  out_beat_t out_beat_r;
  out_beat_t out_beat_nxt;

  // chain wiring
  cell_ctl_t        ctl;
  entry_t           entries  [CAPACITY];
  logic             le_v     [CAPACITY];
  logic             seen_v   [CAPACITY];
  logic [PRI_W-1:0] hit_pri_v[CAPACITY];
  logic [PRI_W-1:0] hit_pri;
  logic [PRI_W-1:0] clamped_pri;
  logic             full;
  logic             empty;
  logic             hit;

  assign accept   = start && !busy_r;
  assign busy_nxt = accept;

  assign full  = (occ_r == CNT_W'(CAPACITY));
  assign empty = (occ_r == '0);
  assign hit   = seen_v[CAPACITY-1];

  // negative priorities clamp to zero
  assign clamped_pri = cmd_r.item_priority[15] ? '0 : cmd_r.item_priority[PRI_W-1:0];

  // the chain only moves in the busy cycle
  assign ctl.insert_en = busy_r && (cmd_r.operation == OP_INSERT) && !full;
  assign ctl.pop_en    = busy_r && (cmd_r.operation == OP_POP) && !empty;
  assign ctl.remove_en = busy_r && (cmd_r.operation == OP_REMOVE);
  assign ctl.value     = cmd_r.item_value;
  assign ctl.prio      = clamped_pri;

  // cell zero sees nothing to its left and the last cell nothing to its right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_le_w;
    logic   seen_in_w;
    logic   occ_w;

    if (i == 0) begin : g_first
      assign left_e    = entries[i];
      assign left_le_w = 1'b1;
      assign seen_in_w = 1'b0;
    end else begin : g_rest
      assign left_e    = entries[i-1];
      assign left_le_w = le_v[i-1];
      assign seen_in_w = seen_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    assign occ_w = (occ_r > CNT_W'(i));

    spq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occupied     (occ_w),
      .left_entry   (left_e),
      .right_entry  (right_e),
      .left_le      (left_le_w),
      .seen_in      (seen_in_w),
      .entry        (entries[i]),
      .le           (le_v[i]),
      .seen_out     (seen_v[i]),
      .hit_priority (hit_pri_v[i])
    );
  end

  // at most one cell reports a first match, so an or merges them
  always_comb begin
    hit_pri = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pri = hit_pri | hit_pri_v[i];
    end
  end

  // next count and result beat
  always_comb begin
    occ_nxt                   = occ_r;
    out_beat_nxt.status       = ST_OK;
    out_beat_nxt.out_value    = '0;
    out_beat_nxt.out_priority = '0;
    unique case (cmd_r.operation)
      OP_INSERT: begin
        if (full) begin
          out_beat_nxt.status = ST_FULL;
        end else begin
          occ_nxt = occ_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          out_beat_nxt.status = ST_EMPTY;
        end else begin
          out_beat_nxt.out_value    = entries[0].value;
          out_beat_nxt.out_priority = entries[0].prio;
          occ_nxt                   = occ_r - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          occ_nxt = occ_r - CNT_W'(1);
        end else begin
          out_beat_nxt.status = ST_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        if (hit) begin
          out_beat_nxt.out_priority = hit_pri;
        end else begin
          out_beat_nxt.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
        // unused codes leave the state alone
        occ_nxt = occ_r;
      end
    endcase
    out_beat_nxt.entry_count = 5'(occ_nxt);
    out_beat_nxt.is_empty    = (occ_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= busy_r;
      if (busy_r) begin
        occ_r <= occ_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_beat;
    end
    if (busy_r) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

@@ rtl/spq_checker.sv @@
// ---------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the request and result ports for timing and result consistency.
// ---------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_beat_t out_beat
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_result_two_later: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing two cycles after accept");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.is_empty == (out_beat.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.entry_count <= 5'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_beat  (out_beat)
);
